>>> rtl/core/frlc_pkg.sv
// Shared types, constants and request codes of the free-rectangle list carve block.
package frlc_pkg;

    localparam int MAX_FREE_RECTS = 64;
    localparam int IDX_W = $clog2(MAX_FREE_RECTS);
    localparam int CNT_W = $clog2(MAX_FREE_RECTS + 1);
    localparam int RAM_DEPTH = 2 * MAX_FREE_RECTS;
    localparam int RAM_AW = IDX_W + 1;
    localparam int CMP_W = (CNT_W > 6) ? CNT_W : 6;

    localparam int XY_W = 12;
    localparam int WH_W = 13;
    localparam int EDGE_W = 14;

    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 13;
    localparam logic [CFG_IDX_W-1:0] CFG_LAYER_WIDTH = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LAYER_HEIGHT = 1'd1;
    localparam logic [WH_W-1:0] LAYER_SIZE_RST = 13'd2048;

    localparam logic [1:0] REQ_RESET = 2'd0;
    localparam logic [1:0] REQ_CARVE = 2'd1;
    localparam logic [1:0] REQ_READ = 2'd2;

    typedef struct packed {
        logic [1:0]      req_type;
        logic [XY_W-1:0] rect_x;
        logic [XY_W-1:0] rect_y;
        logic [WH_W-1:0] rect_w;
        logic [WH_W-1:0] rect_h;
        logic [5:0]      entry_index;
    } t_in_item;

    typedef struct packed {
        logic [6:0]      free_count;
        logic            entry_valid;
        logic [XY_W-1:0] entry_x;
        logic [XY_W-1:0] entry_y;
        logic [WH_W-1:0] entry_w;
        logic [WH_W-1:0] entry_h;
        logic            layer_empty;
        logic            overflow;
    } t_out_item;

    typedef struct packed {
        logic [XY_W-1:0] x;
        logic [XY_W-1:0] y;
        logic [WH_W-1:0] w;
        logic [WH_W-1:0] h;
    } t_rect;

    // occupied rectangle as edges
    typedef struct packed {
        logic [XY_W-1:0]   x;
        logic [XY_W-1:0]   y;
        logic [EDGE_W-1:0] xe;
        logic [EDGE_W-1:0] ye;
    } t_occ;

    // intersection of one free entry with the occupied rectangle
    typedef struct packed {
        logic [XY_W-1:0]   left;
        logic [XY_W-1:0]   top;
        logic [EDGE_W-1:0] right;
        logic [EDGE_W-1:0] bottom;
        logic [EDGE_W-1:0] fxe;
        logic [EDGE_W-1:0] fye;
        logic              overlap;
        logic [3:0]        need;   // left, right, top, bottom pieces
    } t_edges;

    typedef enum logic [2:0] {
        PK_KEEP,
        PK_LEFT,
        PK_RIGHT,
        PK_TOP,
        PK_BOTTOM
    } t_piece_kind;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_EDGE,
        ST_PIECE,
        ST_FINISH,
        ST_FETCH,
        ST_DONE
    } t_state;

endpackage

>>> rtl/core/frlc_rect_ram.sv
// Generic simple dual-port RAM with registered read data.
module frlc_rect_ram #(
    parameter int DEPTH = 128,
    parameter int WIDTH = 50,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/frlc_piece_unit.sv
// Shared edge compare and piece builder used for every entry of a carve.
module frlc_piece_unit (
    input  frlc_pkg::t_rect       i_entry,
    input  frlc_pkg::t_occ        i_occ,
    output frlc_pkg::t_edges      o_edges,
    input  frlc_pkg::t_edges      i_edges_r,
    input  frlc_pkg::t_piece_kind i_kind,
    output frlc_pkg::t_rect       o_piece
);
    import frlc_pkg::*;

    logic [EDGE_W-1:0] fx;
    logic [EDGE_W-1:0] fy;
    logic [EDGE_W-1:0] wa;
    logic [EDGE_W-1:0] wb;
    logic [EDGE_W-1:0] ha;
    logic [EDGE_W-1:0] hb;
    logic [EDGE_W-1:0] wd;
    logic [EDGE_W-1:0] hd;

    always_comb begin
        o_edges.fxe = {2'b00, i_entry.x} + {1'b0, i_entry.w};
        o_edges.fye = {2'b00, i_entry.y} + {1'b0, i_entry.h};
        o_edges.left = (i_entry.x > i_occ.x) ? i_entry.x : i_occ.x;
        o_edges.top = (i_entry.y > i_occ.y) ? i_entry.y : i_occ.y;
        o_edges.right = (o_edges.fxe < i_occ.xe) ? o_edges.fxe : i_occ.xe;
        o_edges.bottom = (o_edges.fye < i_occ.ye) ? o_edges.fye : i_occ.ye;
        o_edges.overlap = (o_edges.right > {2'b00, o_edges.left})
                       && (o_edges.bottom > {2'b00, o_edges.top});
        o_edges.need[0] = o_edges.left > i_entry.x;
        o_edges.need[1] = o_edges.right < o_edges.fxe;
        o_edges.need[2] = o_edges.top > i_entry.y;
        o_edges.need[3] = o_edges.bottom < o_edges.fye;
    end

    // one pair of subtractors serves all piece kinds
    always_comb begin
        fx = {2'b00, i_entry.x};
        fy = {2'b00, i_entry.y};
        o_piece.x = i_entry.x;
        o_piece.y = i_entry.y;
        wa = {1'b0, i_entry.w};
        wb = '0;
        ha = {1'b0, i_entry.h};
        hb = '0;
        case (i_kind)
            PK_LEFT: begin
                wa = {2'b00, i_edges_r.left};
                wb = fx;
            end
            PK_RIGHT: begin
                o_piece.x = i_edges_r.right[XY_W-1:0];
                wa = i_edges_r.fxe;
                wb = i_edges_r.right;
            end
            PK_TOP: begin
                o_piece.x = i_edges_r.left;
                wa = i_edges_r.right;
                wb = {2'b00, i_edges_r.left};
                ha = {2'b00, i_edges_r.top};
                hb = fy;
            end
            PK_BOTTOM: begin
                o_piece.x = i_edges_r.left;
                o_piece.y = i_edges_r.bottom[XY_W-1:0];
                wa = i_edges_r.right;
                wb = {2'b00, i_edges_r.left};
                ha = i_edges_r.fye;
                hb = i_edges_r.bottom;
            end
            default: begin
            end
        endcase
        wd = wa - wb;
        hd = ha - hb;
        o_piece.w = wd[WH_W-1:0];
        o_piece.h = hd[WH_W-1:0];
    end

endmodule

>>> rtl/core/free_rect_list_carve_core.sv
// Top level: free-rectangle list of one atlas layer with carve sequencer.
// Requests enter on i_in_valid / o_in_stall; each request gives one result on
// o_out_valid / i_out_stall. o_in_stall is high while a request is in work.
// The list lives in a two-bank RAM: a carve reads the live bank, writes the
// surviving pieces into the other bank and then swaps banks.
// A reset-list request, an unused code or a read past the list goes straight
// to the result; a read of a listed entry fetches it from the RAM first. A
// carve reads each listed entry from the RAM, compares its edges, which also
// writes an entry kept whole, and cuts each piece in the shared piece builder.
// Reset empties the list (count 0) and sets the layer size to 2048 x 2048.
// One request is in work at a time. A new request is taken while an earlier
// result still waits in the output register; if the receiver stalls, the
// finished result waits in the sequencer until the output register frees.
// Configuration writes (i_cfg_we) are the user's to give only while no request
// is in work; the block itself does not enforce it.
module free_rect_list_carve_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  frlc_pkg::t_in_item                  i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output frlc_pkg::t_out_item                 o_out_data,
    input  logic                                i_cfg_we,
    input  logic [frlc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [frlc_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import frlc_pkg::*;

    t_state r_state;
    t_state n_state;

    logic [WH_W-1:0]  r_layer_w;
    logic [WH_W-1:0]  r_layer_h;
    logic [CNT_W-1:0] r_count;
    logic             r_bank;
    logic             r_out_valid;
    t_out_item        r_out;

    logic [1:0]       r_req;
    t_occ             r_occ;
    logic [CNT_W-1:0] r_rd_idx;
    logic [CNT_W-1:0] r_wr_cnt;
    logic             r_over;
    logic             r_ent_ok;
    t_edges           r_edges;
    logic [3:0]       r_need;
    t_rect            r_head;

    logic             accept;
    logic             out_free;
    logic             idx_ok;
    logic             last;
    logic             emit;
    logic             room;
    logic             we;
    logic [RAM_AW-1:0] waddr;
    t_rect            wdata;
    logic [RAM_AW-1:0] raddr;
    logic [$bits(t_rect)-1:0] rdata_raw;
    t_rect            entry;
    t_edges           edges;
    t_piece_kind      kind;
    t_rect            piece;
    logic [3:0]       need_rest;
    t_rect            full_rect;
    t_occ             occ_in;

    assign accept = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;
    assign idx_ok = CMP_W'(i_in_data.entry_index) < CMP_W'(r_count);
    assign last = (r_rd_idx + CNT_W'(1)) == r_count;
    assign room = r_wr_cnt < CNT_W'(MAX_FREE_RECTS);
    assign full_rect = '{x: '0, y: '0, w: r_layer_w, h: r_layer_h};
    assign entry = t_rect'(rdata_raw);

    always_comb begin
        occ_in.x = i_in_data.rect_x;
        occ_in.y = i_in_data.rect_y;
        occ_in.xe = {2'b00, i_in_data.rect_x} + {1'b0, i_in_data.rect_w};
        occ_in.ye = {2'b00, i_in_data.rect_y} + {1'b0, i_in_data.rect_h};
    end

    frlc_rect_ram #(
        .DEPTH (RAM_DEPTH),
        .WIDTH ($bits(t_rect))
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata_raw)
    );

    frlc_piece_unit u_piece (
        .i_entry   (entry),
        .i_occ     (r_occ),
        .o_edges   (edges),
        .i_edges_r (r_edges),
        .i_kind    (kind),
        .o_piece   (piece)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (i_in_data.req_type == REQ_CARVE) begin
                        n_state = (r_count == '0) ? ST_FINISH : ST_READ;
                    end else if (i_in_data.req_type == REQ_READ && idx_ok) begin
                        n_state = ST_FETCH;
                    end else begin
                        n_state = ST_DONE;
                    end
                end
            end
            ST_READ: n_state = ST_EDGE;
            ST_EDGE: begin
                if (!edges.overlap || edges.need == 4'd0) begin
                    n_state = last ? ST_FINISH : ST_READ;
                end else begin
                    n_state = ST_PIECE;
                end
            end
            ST_PIECE: begin
                if (need_rest == 4'd0) begin
                    n_state = last ? ST_FINISH : ST_READ;
                end
            end
            ST_FINISH: n_state = ST_DONE;
            ST_FETCH:  n_state = ST_DONE;
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        o_in_stall = r_state != ST_IDLE;
        raddr = {r_bank, r_rd_idx[IDX_W-1:0]};
        kind = PK_KEEP;
        need_rest = r_need;
        if (r_state == ST_PIECE) begin
            if (r_need[0]) begin
                kind = PK_LEFT;
                need_rest[0] = 1'b0;
            end else if (r_need[1]) begin
                kind = PK_RIGHT;
                need_rest[1] = 1'b0;
            end else if (r_need[2]) begin
                kind = PK_TOP;
                need_rest[2] = 1'b0;
            end else begin
                kind = PK_BOTTOM;
                need_rest[3] = 1'b0;
            end
        end
        emit = (r_state == ST_EDGE && !edges.overlap) || r_state == ST_PIECE;
        if (r_state == ST_IDLE) begin
            we = accept && i_in_data.req_type == REQ_RESET;
            waddr = {r_bank, IDX_W'(0)};
            wdata = full_rect;
        end else begin
            we = emit && room;
            waddr = {~r_bank, r_wr_cnt[IDX_W-1:0]};
            wdata = piece;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_layer_w <= LAYER_SIZE_RST;
            r_layer_h <= LAYER_SIZE_RST;
            r_count <= '0;
            r_bank <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_LAYER_WIDTH) begin
                    r_layer_w <= i_cfg_data;
                end else if (i_cfg_index == CFG_LAYER_HEIGHT) begin
                    r_layer_h <= i_cfg_data;
                end
            end
            if (accept && i_in_data.req_type == REQ_RESET) begin
                r_count <= CNT_W'(1);
            end
            if (r_state == ST_FINISH) begin
                r_count <= r_wr_cnt;
                r_bank <= ~r_bank;
            end
            if (r_state == ST_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req <= i_in_data.req_type;
            r_occ <= occ_in;
            r_rd_idx <= (i_in_data.req_type == REQ_READ)
                      ? CNT_W'(i_in_data.entry_index) : '0;
            r_wr_cnt <= '0;
            r_over <= 1'b0;
            r_ent_ok <= (i_in_data.req_type == REQ_READ) && idx_ok;
            if (i_in_data.req_type == REQ_RESET) begin
                r_head <= full_rect;
            end
        end
        if (r_state == ST_EDGE) begin
            r_edges <= edges;
            r_need <= edges.need;
        end
        if (r_state == ST_PIECE) begin
            r_need <= need_rest;
        end
        if ((r_state == ST_EDGE && (!edges.overlap || edges.need == 4'd0))
            || (r_state == ST_PIECE && need_rest == 4'd0)) begin
            r_rd_idx <= r_rd_idx + CNT_W'(1);
        end
        if (emit) begin
            if (room) begin
                r_wr_cnt <= r_wr_cnt + CNT_W'(1);
                if (r_wr_cnt == '0) begin
                    r_head <= piece;
                end
            end else begin
                r_over <= 1'b1;
            end
        end
        if (r_state == ST_DONE && out_free) begin
            r_out.free_count <= 7'(r_count);
            r_out.entry_valid <= r_ent_ok;
            r_out.entry_x <= r_ent_ok ? entry.x : '0;
            r_out.entry_y <= r_ent_ok ? entry.y : '0;
            r_out.entry_w <= r_ent_ok ? entry.w : '0;
            r_out.entry_h <= r_ent_ok ? entry.h : '0;
            r_out.layer_empty <= (r_count == CNT_W'(1)) && (r_head == full_rect);
            r_out.overflow <= (r_req == REQ_CARVE) && r_over;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data = r_out;

endmodule
